FILE: design/tkmh_pkg.sv
// Shared types and constants for the top-k max-heap selector.
`timescale 1ns / 1ps
`default_nettype none

package tkmh_pkg;

  // Field widths of the request and response payloads.
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned IDX_FIELD_W = 22;
  localparam int unsigned DIST_W      = 31;
  localparam int unsigned FILL_W      = 5;
  localparam int unsigned KEEP_W      = 5;

  // Reset value of the keep count register.
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  // Bit pattern of the largest finite float32, reported while the heap is not full.
  localparam logic [DIST_W-1:0] FLT_MAX_BITS = 31'h7F7F_FFFF;

  // Request action codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_OFFER  = 2'd1,
    ACT_DRAIN  = 2'd2,
    ACT_STATUS = 2'd3
  } action_e;

  // One request on the input channel.
  typedef struct packed {
    action_e                action;
    logic [IDX_FIELD_W-1:0] cand_index;
    logic [DIST_W-1:0]      cand_distance;
  } req_t;

  // One response on the output channel.
  typedef struct packed {
    logic [IDX_FIELD_W-1:0] out_index;
    logic [DIST_W-1:0]      out_distance;
    logic                   entry_valid;
    logic                   accepted;
    logic [FILL_W-1:0]      fill_count;
    logic [DIST_W-1:0]      worst_distance;
    logic                   last;
  } rsp_t;

endpackage

`default_nettype wire

FILE: design/tkmh_stream_if.sv
// Valid/ready stream interface that carries one payload of a parameterized type.
`timescale 1ns / 1ps
`default_nettype none

interface tkmh_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

FILE: design/top_k_max_heap_selector_core.sv
// Top level of the top-k max-heap selector: sequencer, heap memory and output register.
`timescale 1ns / 1ps
`default_nettype none

// Keeps the k smallest (index, distance) candidates in a binary max-heap held in a
// synchronous memory with one write port and two registered read ports.
// Requests arrive on req_i (clear, offer, drain, status); responses leave on rsp_o.
// The user writes the keep count through cfg_we_i / cfg_wdata_i only while the block is
// idle; the block does not enforce this. One request is worked on at a time; req_i is
// ready whenever the sequencer is idle, even while a finished response still waits in
// the output register. Clear and status go straight to the response state.
// Offer: a read state and a compare-and-write state per heap level of the sift, ending in
// a write of the new entry and then the response state; a rejected offer goes straight
// to the response state. Drain: after a first memory read, one entry per cycle while the
// receiver takes them, last set on the final entry. The next request can be taken in the
// cycle after the final response is loaded.
// When the receiver stalls, the sequencer holds before loading the output register and
// memory read data is kept until it is taken.
// Reset empties the heap and sets the keep count to 16; no clearing pass is needed since
// only entries below the fill count are ever used.
module top_k_max_heap_selector_core
  import tkmh_pkg::*;
#(
  parameter int unsigned MAX_KEEP   = 16,
  parameter int unsigned INDEX_BITS = 22
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [KEEP_W-1:0] cfg_wdata_i,
  tkmh_stream_if.sink            req_i,
  tkmh_stream_if.source          rsp_o
);

  // Derived widths.
  localparam int unsigned AW    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned FW    = $clog2(MAX_KEEP + 1);
  localparam int unsigned CW    = (FW > KEEP_W) ? FW : KEEP_W;
  localparam int unsigned IDX_W = (INDEX_BITS < IDX_FIELD_W) ? INDEX_BITS : IDX_FIELD_W;
  localparam int unsigned LW    = AW + 2;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DR_OUT,
    S_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [KEEP_W-1:0] keep_q, keep_d;
  logic [DIST_W-1:0] root_q, root_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  entry_t            carry_q, carry_d;
  logic              acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  // Heap memory and its ports.
  entry_t        mem_q [MAX_KEEP];
  entry_t        rd_a_q, rd_b_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          rd_en;
  logic [AW-1:0] raddr_a, raddr_b;

  // Helper values.
  logic [CW-1:0]     keep_ext, k_ext, fill_ext;
  logic              heap_full;
  logic [DIST_W-1:0] worst;
  logic              slot_free;
  logic              req_fire;
  logic [AW-1:0]     up_addr;
  logic [LW-1:0]     left_w, right_w, fill_w;
  logic              take_left, take_right;
  logic [DIST_W-1:0] cur_big;
  logic              drain_last;
  req_t              req;

  assign req = req_i.payload;

  // Effective keep count, saturated into 1..MAX_KEEP.
  assign keep_ext  = CW'(keep_q);
  assign fill_ext  = CW'(fill_q);
  assign k_ext     = (keep_ext == '0) ? CW'(1) :
                     (keep_ext > CW'(MAX_KEEP)) ? CW'(MAX_KEEP) : keep_ext;
  assign heap_full = (fill_ext >= k_ext) && (fill_q != '0);
  assign worst     = heap_full ? root_q : FLT_MAX_BITS;

  assign slot_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire  = req_i.valid && (state_q == S_IDLE);

  // Parent and child addresses of the current sift position.
  assign up_addr = (pos_q - AW'(1)) >> 1;
  assign left_w  = {1'b0, pos_q, 1'b1};
  assign right_w = left_w + LW'(1);
  assign fill_w  = LW'(fill_q);

  // Child selection: the left child wins ties, a move needs strictly greater.
  assign take_left  = rd_a_q.distance > carry_q.distance;
  assign cur_big    = take_left ? rd_a_q.distance : carry_q.distance;
  assign take_right = (right_w < fill_w) && (rd_b_q.distance > cur_big);

  assign drain_last = (FW'(cnt_q) + FW'(1)) == fill_q;

  // Sequencer next-state and datapath logic.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    keep_d      = cfg_we_i ? cfg_wdata_i : keep_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    carry_d     = carry_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = carry_q;
    rd_en       = 1'b0;
    raddr_a     = up_addr;
    raddr_b     = right_w[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          carry_d.idx      = IDX_W'(req.cand_index);
          carry_d.distance = req.cand_distance;
          acc_d            = 1'b0;
          unique case (req.action)
            ACT_CLEAR: begin
              fill_d  = '0;
              state_d = S_RESP;
            end
            ACT_OFFER: begin
              if ((fill_ext < k_ext) && (fill_q < FW'(MAX_KEEP))) begin
                // Append at the end and sift up.
                fill_d  = fill_q + FW'(1);
                pos_d   = AW'(fill_q);
                acc_d   = 1'b1;
                state_d = S_UP_RD;
              end else if ((fill_q != '0) && (req.cand_distance < root_q)) begin
                // Replace the root and sift down.
                pos_d   = '0;
                acc_d   = 1'b1;
                state_d = S_DN_RD;
              end else begin
                state_d = S_RESP;
              end
            end
            ACT_DRAIN: begin
              if (fill_q == '0) begin
                state_d = S_RESP;
              end else begin
                rd_en   = 1'b1;
                raddr_a = '0;
                cnt_d   = '0;
                state_d = S_DR_OUT;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we  = 1'b1;
          state_d = S_RESP;
        end else begin
          rd_en   = 1'b1;
          raddr_a = up_addr;
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        mem_we = 1'b1;
        if (carry_q.distance <= rd_a_q.distance) begin
          state_d = S_RESP;
        end else begin
          mem_wdata = rd_a_q;
          pos_d     = up_addr;
          state_d   = S_UP_RD;
        end
      end

      S_DN_RD: begin
        if (left_w >= fill_w) begin
          mem_we  = 1'b1;
          state_d = S_RESP;
        end else begin
          rd_en   = 1'b1;
          raddr_a = left_w[AW-1:0];
          raddr_b = right_w[AW-1:0];
          state_d = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        mem_we = 1'b1;
        if (take_right) begin
          mem_wdata = rd_b_q;
          pos_d     = right_w[AW-1:0];
          state_d   = S_DN_RD;
        end else if (take_left) begin
          mem_wdata = rd_a_q;
          pos_d     = left_w[AW-1:0];
          state_d   = S_DN_RD;
        end else begin
          state_d = S_RESP;
        end
      end

      S_DR_OUT: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.out_index      = IDX_FIELD_W'(rd_a_q.idx);
          out_d.out_distance   = rd_a_q.distance;
          out_d.entry_valid    = 1'b1;
          out_d.accepted       = 1'b0;
          out_d.fill_count     = FILL_W'(fill_q);
          out_d.worst_distance = worst;
          out_d.last           = drain_last;
          if (drain_last) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            raddr_a = cnt_q + AW'(1);
            cnt_d   = cnt_q + AW'(1);
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.out_index      = '0;
          out_d.out_distance   = '0;
          out_d.entry_valid    = 1'b0;
          out_d.accepted       = acc_q;
          out_d.fill_count     = FILL_W'(fill_q);
          out_d.worst_distance = worst;
          out_d.last           = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Mirror of the root distance, kept for the full-heap compare and the worst report.
    root_d = (mem_we && (mem_waddr == '0)) ? mem_wdata.distance : root_q;
  end

  // State, control and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      keep_q      <= KEEP_RESET;
      root_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      carry_q     <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      keep_q      <= keep_d;
      root_q      <= root_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      carry_q     <= carry_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[raddr_a];
      rd_b_q <= mem_q[raddr_b];
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench for the top-k max-heap selector: directed rows, then random requests against a heap predictor.
`timescale 1ns / 1ps

module tb;
  import tkmh_pkg::*;

  localparam int unsigned MAX_KEEP   = 16;
  localparam int unsigned INDEX_BITS = 22;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned NUM_PHASES = 8;

  // One row of the directed stimulus: either a keep count write or a request.
  typedef struct packed {
    logic              is_cfg;
    logic [KEEP_W-1:0] keep;
    req_t              req;
    logic              typed;
    rsp_t              exp;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [KEEP_W-1:0] cfg_wdata_i = '0;

  tkmh_stream_if #(.payload_t(req_t)) req_if ();
  tkmh_stream_if #(.payload_t(rsp_t)) rsp_if ();

  top_k_max_heap_selector_core #(
    .MAX_KEEP  (MAX_KEEP),
    .INDEX_BITS(INDEX_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // Heap predictor state.
  logic [IDX_FIELD_W-1:0] heap_idx  [MAX_KEEP];
  logic [DIST_W-1:0]      heap_dist [MAX_KEEP];
  int unsigned            heap_cnt;
  logic [KEEP_W-1:0]      keep_reg;

  rsp_t step_rsps[$];
  rsp_t pending_rsps[$];
  stim_row_t dir_rows[$];

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned request_count = 0;
  int unsigned cfg_count = 0;
  logic send_busy = 1'b1;
  logic recv_busy = 1'b1;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;

  // Keep count as the heap uses it: zero acts as one, large values saturate.
  function automatic int unsigned eff_keep();
    if (keep_reg < 1) return 1;
    if (keep_reg > MAX_KEEP) return MAX_KEEP;
    return keep_reg;
  endfunction

  function automatic logic [DIST_W-1:0] worst_now();
    if (heap_cnt < eff_keep() || heap_cnt == 0) return FLT_MAX_BITS;
    return heap_dist[0];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [IDX_FIELD_W-1:0] ti;
    logic [DIST_W-1:0]      td;
    ti = heap_idx[a];
    td = heap_dist[a];
    heap_idx[a] = heap_idx[b];
    heap_dist[a] = heap_dist[b];
    heap_idx[b] = ti;
    heap_dist[b] = td;
  endfunction

  // Move a new entry toward the root while it beats its parent.
  function automatic void sift_up(int unsigned start);
    int unsigned pos;
    int unsigned up;
    logic done;
    pos = start;
    done = 1'b0;
    while (!done && pos > 0 && pos < MAX_KEEP) begin
      up = (pos - 1) / 2;
      if (heap_dist[pos] <= heap_dist[up]) begin
        done = 1'b1;
      end else begin
        swap_slots(pos, up);
        pos = up;
      end
    end
  endfunction

  // Push the root down; the left child wins a tie and a swap needs strictly greater.
  function automatic void sift_down(int unsigned span);
    int unsigned pos;
    int unsigned big;
    int unsigned cnt;
    logic done;
    pos = 0;
    done = 1'b0;
    cnt = (span > MAX_KEEP) ? MAX_KEEP : span;
    while (!done) begin
      big = pos;
      if (2 * pos + 1 < cnt && heap_dist[2 * pos + 1] > heap_dist[big]) big = 2 * pos + 1;
      if (2 * pos + 2 < cnt && heap_dist[2 * pos + 2] > heap_dist[big]) big = 2 * pos + 2;
      if (big == pos) begin
        done = 1'b1;
      end else begin
        swap_slots(pos, big);
        pos = big;
      end
    end
  endfunction

  // Apply one request to the predicted heap and collect the responses it causes.
  function automatic void predict_request(req_t r);
    int unsigned k;
    int unsigned n;
    rsp_t x;
    step_rsps.delete();
    k = eff_keep();
    x = '0;
    x.last = 1'b1;
    case (r.action)
      ACT_CLEAR: begin
        heap_cnt = 0;
      end
      ACT_OFFER: begin
        if (heap_cnt < k && heap_cnt < MAX_KEEP) begin
          heap_idx[heap_cnt] = r.cand_index;
          heap_dist[heap_cnt] = r.cand_distance;
          heap_cnt++;
          sift_up(heap_cnt - 1);
          x.accepted = 1'b1;
        end else if (heap_cnt > 0 && r.cand_distance < heap_dist[0]) begin
          heap_idx[0] = r.cand_index;
          heap_dist[0] = r.cand_distance;
          sift_down(heap_cnt);
          x.accepted = 1'b1;
        end
      end
      default: begin
      end
    endcase
    n = (heap_cnt > MAX_KEEP) ? MAX_KEEP : heap_cnt;
    x.fill_count = heap_cnt[FILL_W-1:0];
    x.worst_distance = worst_now();
    if (r.action == ACT_DRAIN && n > 0) begin
      for (int unsigned i = 0; i < n; i++) begin
        x.out_index = heap_idx[i];
        x.out_distance = heap_dist[i];
        x.entry_valid = 1'b1;
        x.last = (i + 1 == n);
        step_rsps.push_back(x);
      end
    end else begin
      step_rsps.push_back(x);
    end
  endfunction

  function automatic rsp_t plain_rsp(logic acc, int unsigned fill, logic [DIST_W-1:0] worst);
    rsp_t x;
    x = '0;
    x.accepted = acc;
    x.fill_count = fill[FILL_W-1:0];
    x.worst_distance = worst;
    x.last = 1'b1;
    return x;
  endfunction

  function automatic stim_row_t mk_row(logic is_cfg, logic [KEEP_W-1:0] keep, action_e act,
                                       logic [IDX_FIELD_W-1:0] idx,
                                       logic [DIST_W-1:0] cand_dist,
                                       logic typed, rsp_t exp);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.keep = keep;
    row.req.action = act;
    row.req.cand_index = idx;
    row.req.cand_distance = cand_dist;
    row.typed = typed;
    row.exp = exp;
    return row;
  endfunction

  // Distances: small values for ties, full random, and the top of the range.
  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(0, 4))
      0, 1: return DIST_W'($urandom_range(0, 40));
      2, 3: return DIST_W'($urandom);
      default: return $urandom_range(0, 1) ? FLT_MAX_BITS : 31'h7FFF_FFFF;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) r.action = ACT_OFFER;
    else if (pick < 86) r.action = ACT_DRAIN;
    else if (pick < 93) r.action = ACT_STATUS;
    else r.action = ACT_CLEAR;
    r.cand_index = IDX_FIELD_W'($urandom);
    r.cand_distance = pick_distance();
    return r;
  endfunction

  // Offer one request after a random gap; predict its responses once it is taken.
  task automatic send_request(req_t r, logic typed, rsp_t exp);
    int unsigned gap;
    gap = send_busy ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    predict_request(r);
    if (typed) pending_rsps.push_back(exp);
    else foreach (step_rsps[i]) pending_rsps.push_back(step_rsps[i]);
    request_count++;
    if ($urandom_range(0, 24) == 0) send_busy = ~send_busy;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted response has come back.
  task automatic sender_idle();
    req_if.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the keep count while the block is idle.
  task automatic write_keep(logic [KEEP_W-1:0] k);
    sender_idle();
    repeat (12) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= k;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    keep_reg = k;
    cfg_count++;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      error_count++;
      if (error_count <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Compare every response taken from the block with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t exp;
    rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (pending_rsps.size() == 0) begin
        error_count++;
        if (error_count <= 40)
          $display("%0t: response with nothing expected, expected none, actual %h", $time, got);
      end else begin
        exp = pending_rsps.pop_front();
        check_field("out_index", exp.out_index, got.out_index);
        check_field("out_distance", exp.out_distance, got.out_distance);
        check_field("entry_valid", exp.entry_valid, got.entry_valid);
        check_field("accepted", exp.accepted, got.accepted);
        check_field("fill_count", exp.fill_count, got.fill_count);
        check_field("worst_distance", exp.worst_distance, got.worst_distance);
        check_field("last", exp.last, got.last);
      end
      checked_count++;
    end
  end

  // Response side: random stalls, stretches without them, and one long hold-off.
  initial begin
    int unsigned gap;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else begin
        gap = recv_busy ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      if ($urandom_range(0, 29) == 0) recv_busy = ~recv_busy;
      @(negedge clk_i);
    end
  end

  // Run ends with a failure if it takes far longer than the slowest correct run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  // Request side and run control.
  initial begin
    rsp_t none;
    rsp_t empty_rsp;
    stim_row_t row;
    int unsigned items;
    logic [KEEP_W-1:0] k;
    none = '0;
    empty_rsp = plain_rsp(1'b0, 0, FLT_MAX_BITS);
    req_if.valid = 1'b0;
    req_if.payload = '0;
    heap_cnt = 0;
    keep_reg = KEEP_RESET;
    foreach (heap_idx[i]) begin
      heap_idx[i] = '0;
      heap_dist[i] = '0;
    end

    // Directed rows: reset state, field extremes, keep count limits, ties, k below fill.
    dir_rows.push_back(mk_row(0, 0, ACT_STATUS, 0, 0, 1, empty_rsp));
    dir_rows.push_back(mk_row(0, 0, ACT_DRAIN, 22'h3F_FFFF, 31'h7FFF_FFFF, 1, empty_rsp));
    dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 0, 0, 1, plain_rsp(1, 1, FLT_MAX_BITS)));
    dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 22'h3F_FFFF, 31'h7FFF_FFFF, 1,
                              plain_rsp(1, 2, FLT_MAX_BITS)));
    dir_rows.push_back(mk_row(0, 0, ACT_DRAIN, 0, 0, 0, none));
    dir_rows.push_back(mk_row(0, 0, ACT_CLEAR, 22'h3F_FFFF, 31'h7FFF_FFFF, 1, empty_rsp));
    dir_rows.push_back(mk_row(1, 5'd1, ACT_STATUS, 0, 0, 0, none));
    dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 5, 1000, 1, plain_rsp(1, 1, 1000)));
    dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 6, 1000, 1, plain_rsp(0, 1, 1000)));
    dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 7, 999, 1, plain_rsp(1, 1, 999)));
    dir_rows.push_back(mk_row(1, 5'd0, ACT_STATUS, 0, 0, 0, none));
    dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 8, 31'h7FFF_FFFF, 1, plain_rsp(0, 1, 999)));
    dir_rows.push_back(mk_row(1, 5'd31, ACT_STATUS, 0, 0, 0, none));
    dir_rows.push_back(mk_row(0, 0, ACT_STATUS, 1, 1, 1, plain_rsp(0, 1, FLT_MAX_BITS)));
    dir_rows.push_back(mk_row(0, 0, ACT_CLEAR, 0, 0, 1, empty_rsp));
    dir_rows.push_back(mk_row(1, 5'd4, ACT_STATUS, 0, 0, 0, none));
    for (int i = 0; i < 4; i++)
      dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 10 + i, 50, 0, none));
    // Equal children below the new root: the left one must move up.
    dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 14, 10, 0, none));
    dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 15, 60, 1, plain_rsp(0, 4, 50)));
    dir_rows.push_back(mk_row(0, 0, ACT_DRAIN, 0, 0, 0, none));
    // Lower k below the fill without a clear; the sift still spans all entries.
    dir_rows.push_back(mk_row(1, 5'd2, ACT_STATUS, 0, 0, 0, none));
    dir_rows.push_back(mk_row(0, 0, ACT_OFFER, 16, 20, 0, none));
    dir_rows.push_back(mk_row(0, 0, ACT_DRAIN, 0, 0, 0, none));
    dir_rows.push_back(mk_row(0, 0, ACT_STATUS, 0, 0, 0, none));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) write_keep(row.keep);
      else send_request(row.req, row.typed, row.exp);
    end

    // Random phases, each under its own keep count, mostly offers, closed by a drain.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: k = 5'd16;
        1: k = 5'd1;
        2: k = 5'd31;
        3: k = 5'd0;
        default: k = KEEP_W'($urandom_range(0, 31));
      endcase
      write_keep(k);
      send_busy = $urandom_range(0, 1);
      if (p == 4) hold_off_req = 1'b1;
      if ($urandom_range(0, 1))
        send_request('{ACT_CLEAR, IDX_FIELD_W'($urandom), pick_distance()}, 0, none);
      items = $urandom_range(36, 42);
      for (int unsigned n = 0; n < items; n++) begin
        send_request(random_request(), 0, none);
        if ($urandom_range(0, 19) == 0) sender_idle();
      end
      send_request('{ACT_DRAIN, IDX_FIELD_W'($urandom), pick_distance()}, 0, none);
    end

    // Wait for every prediction to be met, then let the block settle.
    sender_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d responses over %0d keep count writes,",
             request_count, checked_count, cfg_count);
    $display("with ties, saturated and lowered keep counts, and a long output stall.");
    if (error_count == 0 && pending_rsps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
